>>> hdl/hcbd_pkg.sv
// Shared types, codes and the hex digit function for the chunked body decoder.
package hcbd_pkg;

    // Default width of the chunk size counter.
    localparam int SIZE_BITS_DEF = 32;

    // Value of hex_digit for a byte that is not a hex digit.
    localparam logic [4:0] NOT_HEX = 5'd16;

    // Line control bytes.
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Decoder phase, one-hot.
    typedef enum logic [4:0] {
        PH_SIZE  = 5'b00001,
        PH_SKIP  = 5'b00010,
        PH_DATA  = 5'b00100,
        PH_TRAIL = 5'b01000,
        PH_DONE  = 5'b10000
    } t_phase;

    // Reason the body ended.
    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_ZERO    = 2'd1,
        CAUSE_NODIGIT = 2'd2,
        CAUSE_INPUT   = 2'd3
    } t_cause;

    // One result beat.
    typedef struct packed {
        logic [7:0] body_byte;
        logic       byte_valid;
        logic       body_end;
        t_cause     end_cause;
    } t_result;

    // Hex digit value of an ASCII byte, either case; NOT_HEX otherwise.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] v;
        v = NOT_HEX;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h37);
        end
        return v;
    endfunction

endpackage

>>> hdl/hcbd_step.sv
// Next-state and result logic for one input byte of the chunked body decoder.
module hcbd_step
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  t_phase               i_phase,
    input  logic [SIZE_BITS-1:0] i_rem,
    input  logic                 i_saw,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output t_phase               o_phase,
    output logic [SIZE_BITS-1:0] o_rem,
    output logic                 o_saw,
    output logic                 o_emit,
    output t_result              o_result
);

    logic [4:0]           hv;
    logic                 is_hex;
    logic                 is_lf;
    logic                 is_crlf;
    logic [SIZE_BITS-1:0] sz_rem;
    logic                 sz_saw;
    logic [SIZE_BITS+3:0] acc;
    logic [SIZE_BITS-1:0] acc_sat;
    t_cause               le_cause;
    logic [SIZE_BITS-1:0] dec;
    t_cause               cause;

    // Byte classification.
    assign hv      = hex_digit(i_data_byte);
    assign is_hex  = (hv != NOT_HEX);
    assign is_lf   = (i_data_byte == CH_LF);
    assign is_crlf = is_lf || (i_data_byte == CH_CR);

    // A size line that starts after a chunk's trailer begins from a cleared count.
    assign sz_rem = (i_phase == PH_TRAIL) ? '0 : i_rem;
    assign sz_saw = (i_phase == PH_TRAIL) ? 1'b0 : i_saw;

    // Shift in one hex digit; saturate when the count would overflow.
    assign acc     = {sz_rem, 4'b0000} + {{SIZE_BITS{1'b0}}, hv[3:0]};
    assign acc_sat = (|acc[SIZE_BITS+3:SIZE_BITS]) ? '1 : acc[SIZE_BITS-1:0];

    // Outcome of the newline that closes a size line.
    assign le_cause = !sz_saw ? CAUSE_NODIGIT : ((sz_rem == '0) ? CAUSE_ZERO : CAUSE_NONE);

    // Payload countdown, held at zero.
    assign dec = (i_rem != '0) ? (i_rem - {{(SIZE_BITS-1){1'b0}}, 1'b1}) : '0;

    // Phase transitions and result formation.
    always_comb begin
        o_phase  = i_phase;
        o_rem    = i_rem;
        o_saw    = i_saw;
        o_emit   = 1'b0;
        cause    = CAUSE_NONE;
        o_result = '{body_byte: 8'h00, byte_valid: 1'b0, body_end: 1'b0,
                     end_cause: CAUSE_NONE};

        unique case (i_phase) inside
            PH_SIZE, PH_TRAIL: begin
                if (i_phase == PH_TRAIL && is_crlf) begin
                    o_phase = PH_TRAIL;
                end else if (is_hex) begin
                    o_phase = PH_SIZE;
                    o_rem   = acc_sat;
                    o_saw   = 1'b1;
                end else if (is_lf) begin
                    o_rem = sz_rem;
                    o_saw = sz_saw;
                    cause = le_cause;
                    if (le_cause == CAUSE_NONE) begin
                        o_phase = PH_DATA;
                    end
                end else begin
                    o_phase = PH_SKIP;
                    o_rem   = sz_rem;
                    o_saw   = sz_saw;
                end
            end
            PH_SKIP: begin
                if (is_lf) begin
                    cause = le_cause;
                    if (le_cause == CAUSE_NONE) begin
                        o_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                o_emit              = 1'b1;
                o_result.body_byte  = i_data_byte;
                o_result.byte_valid = 1'b1;
                o_rem               = dec;
                if (dec == '0) begin
                    o_phase = PH_TRAIL;
                end
            end
            default: begin
                o_phase = i_phase;
            end
        endcase

        // A size line that ends the body.
        if (cause != CAUSE_NONE) begin
            o_emit   = 1'b1;
            o_phase  = PH_DONE;
            o_result.body_end = 1'b1;
        end

        // End of the input buffer: report it if still active, then re-arm.
        if (i_last_byte) begin
            if (i_phase != PH_DONE && cause == CAUSE_NONE) begin
                o_emit            = 1'b1;
                o_result.body_end = 1'b1;
                cause             = CAUSE_INPUT;
            end
            o_phase = PH_SIZE;
            o_rem   = '0;
            o_saw   = 1'b0;
        end

        o_result.end_cause = cause;
    end

endmodule

>>> hdl/hcbd_out_buf.sv
// Result register with a skid stage, so results flow at one beat per cycle while i_ready is high.
module hcbd_out_buf
    import hcbd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_can_push,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop        = r_out_valid && i_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

`ifndef SYNTHESIS
    // The skid stage only fills behind a held result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a beat while the result register is empty");

    // A beat held in the skid stage moves up when the result is taken.
    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && i_ready |=> r_out_valid && !r_skid_valid)
        else $error("skid beat not moved up after the result was taken");

    // No push is offered while the skid stage is full.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("push while the skid stage is full");
`endif

endmodule

>>> hdl/http_chunked_body_decoder_core.sv
// Top level of the HTTP chunked body decoder: decode state and result buffering.
//
//  channel  direction  handshake          payload
//  input    in         i_valid / o_ready  i_data_byte, i_last_byte
//  result   out        o_valid / i_ready  o_body_byte, o_byte_valid, o_body_end, o_end_cause
//
// One byte is taken every cycle while the result skid stage is empty; each byte is
// decoded in the cycle it is accepted and its result, if any, goes to the result register
// or, behind a held result, to the skid stage. A stalled output lets one more result into
// the skid stage, after which o_ready drops until the result register drains. Synchronous
// active-low reset returns the decoder to the start of a size line with no results pending.
module http_chunked_body_decoder_core
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_body_byte,
    output logic       o_byte_valid,
    output logic       o_body_end,
    output logic [1:0] o_end_cause
);

    t_phase               r_phase;
    t_phase               n_phase;
    logic [SIZE_BITS-1:0] r_rem;
    logic [SIZE_BITS-1:0] n_rem;
    logic                 r_saw;
    logic                 n_saw;
    logic                 emit;
    t_result              step_result;
    t_result              out_result;
    logic                 can_push;
    logic                 accept;

    assign o_ready = can_push;
    assign accept  = i_valid && can_push;

    // Per-byte decode.
    hcbd_step #(
        .SIZE_BITS(SIZE_BITS)
    ) u_step (
        .i_phase    (r_phase),
        .i_rem      (r_rem),
        .i_saw      (r_saw),
        .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte),
        .o_phase    (n_phase),
        .o_rem      (n_rem),
        .o_saw      (n_saw),
        .o_emit     (emit),
        .o_result   (step_result)
    );

    // Decoder state advances on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_rem   <= '0;
            r_saw   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_saw   <= n_saw;
        end
    end

    // Result register and skid stage.
    hcbd_out_buf u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (accept && emit),
        .i_result  (step_result),
        .o_can_push(can_push),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (out_result)
    );

    assign o_body_byte  = out_result.body_byte;
    assign o_byte_valid = out_result.byte_valid;
    assign o_body_end   = out_result.body_end;
    assign o_end_cause  = out_result.end_cause;

`ifndef SYNTHESIS
    // Payload phase always has bytes left to pass.
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_rem != '0)
        else $error("payload phase entered with an empty chunk count");

    // Without a digit on the size line the count stays clear.
    a_no_digit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SIZE || r_phase == PH_SKIP) && !r_saw |-> r_rem == '0)
        else $error("size count set without a hex digit");

    // The final byte of a buffer re-arms the decoder.
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_byte |=> r_phase == PH_SIZE && r_rem == '0 && !r_saw)
        else $error("decoder not re-armed after the last byte");

    // An end cause appears exactly on ending beats.
    a_cause_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_body_end == (o_end_cause != CAUSE_NONE)))
        else $error("end cause and body end disagree");
`endif

endmodule

>>> sim/tb_http_chunked_body_decoder_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the HTTP chunked body decoder core.
module tb_http_chunked_body_decoder_core;
    import hcbd_pkg::*;

    localparam int SIZE_BITS = SIZE_BITS_DEF;
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;
    localparam int RANDOM_BEATS = 1550;
    localparam int MAX_ERR_PRINT = 10;
    localparam int N_DIR = 28;

    // One row of the directed table; res is used only when typed is set.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_result    res;
    } t_row;

    localparam t_result NO_RES = '{8'h00, 1'b0, 1'b0, CAUSE_NONE};

    // Directed bodies: skipped digits after text, payload extremes, a newline as
    // payload, a zero-size end, a line without digits, size saturation and input
    // ending both on a size line and inside the payload.
    localparam t_row DIR_ROWS [N_DIR] = '{
        '{"2",    1'b0, 1'b0, NO_RES},
        '{"z",    1'b0, 1'b0, NO_RES},
        '{"5",    1'b0, 1'b0, NO_RES},
        '{CH_LF,  1'b0, 1'b0, NO_RES},
        '{8'h00,  1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, CAUSE_NONE}},
        '{8'hFF,  1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, CAUSE_NONE}},
        '{CH_CR,  1'b0, 1'b0, NO_RES},
        '{"1",    1'b0, 1'b0, NO_RES},
        '{CH_LF,  1'b0, 1'b0, NO_RES},
        '{CH_LF,  1'b0, 1'b1, '{CH_LF, 1'b1, 1'b0, CAUSE_NONE}},
        '{"0",    1'b0, 1'b0, NO_RES},
        '{CH_LF,  1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, CAUSE_ZERO}},
        '{"x",    1'b1, 1'b0, NO_RES},
        '{";",    1'b0, 1'b0, NO_RES},
        '{CH_LF,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, CAUSE_NODIGIT}},
        '{"F",    1'b0, 1'b0, NO_RES},
        '{"f",    1'b0, 1'b0, NO_RES},
        '{"F",    1'b0, 1'b0, NO_RES},
        '{"F",    1'b0, 1'b0, NO_RES},
        '{"F",    1'b0, 1'b0, NO_RES},
        '{"F",    1'b0, 1'b0, NO_RES},
        '{"F",    1'b0, 1'b0, NO_RES},
        '{"F",    1'b0, 1'b0, NO_RES},
        '{"a",    1'b0, 1'b0, NO_RES},
        '{CH_LF,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, CAUSE_INPUT}},
        '{"1",    1'b0, 1'b0, NO_RES},
        '{CH_LF,  1'b0, 1'b0, NO_RES},
        '{8'h80,  1'b1, 1'b1, '{8'h80, 1'b1, 1'b1, CAUSE_INPUT}}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_body_byte;
    logic       o_byte_valid;
    logic       o_body_end;
    logic [1:0] o_end_cause;

    // Decoder state as predicted from the accepted input beats.
    t_phase                dec_phase = PH_SIZE;
    logic [SIZE_BITS-1:0]  dec_remaining = '0;
    logic                  dec_saw_digit = 1'b0;

    t_result     pending_results[$];
    logic [7:0]  body_q[$];
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned decoded_beats = 0;
    int unsigned sent_beats = 0;
    int unsigned payload_beats = 0;
    int unsigned ends_by_cause [4] = '{0, 0, 0, 0};
    int unsigned mismatches = 0;

    http_chunked_body_decoder_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_body_byte  (o_body_byte),
        .o_byte_valid (o_byte_valid),
        .o_body_end   (o_body_end),
        .o_end_cause  (o_end_cause)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog for a hung or silent block.
    initial begin
        #5_000_000;
        $display("[http_chunked_body_decoder_core] ERROR");
        $finish;
    end

    // Hex value of an ASCII byte, folding case by setting bit 5; 16 when not hex.
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39) begin
            return 5'(c - 8'h30);
        end
        if (folded >= 8'h61 && folded <= 8'h66) begin
            return 5'(folded - 8'h61 + 8'd10);
        end
        return NOT_HEX;
    endfunction

    task automatic clear_decoder();
        dec_phase = PH_SIZE;
        dec_remaining = '0;
        dec_saw_digit = 1'b0;
    endtask

    // Newline of a size line: either the body ends or the payload starts.
    task automatic close_size_line(output t_cause cause);
        cause = CAUSE_NONE;
        if (!dec_saw_digit) begin
            cause = CAUSE_NODIGIT;
        end else if (dec_remaining == '0) begin
            cause = CAUSE_ZERO;
        end else begin
            dec_phase = PH_DATA;
        end
    endtask

    // A byte in the digit part of a size line; the size saturates at all ones.
    task automatic size_line_char(input logic [7:0] c, output t_cause cause);
        logic [4:0]           v;
        logic [SIZE_BITS+3:0] grown;
        logic [SIZE_BITS+3:0] v_wide;
        cause = CAUSE_NONE;
        v = digit_value(c);
        if (v != NOT_HEX) begin
            v_wide = '0;
            v_wide[4:0] = v;
            grown = {dec_remaining, 4'h0} + v_wide;
            dec_remaining = (grown > {4'h0, SIZE_MAX}) ? SIZE_MAX : grown[SIZE_BITS-1:0];
            dec_saw_digit = 1'b1;
        end else if (c == CH_LF) begin
            close_size_line(cause);
        end else begin
            dec_phase = PH_SKIP;
        end
    endtask

    // Predict the result, if any, of one accepted input beat.
    task automatic decode_byte(input logic [7:0] d, input logic l,
                               output bit produced, output t_result res);
        t_cause cause;
        bit     was_done;
        was_done = (dec_phase == PH_DONE);
        cause = CAUSE_NONE;
        produced = 1'b0;
        res = NO_RES;
        case (dec_phase)
            PH_TRAIL: begin
                if (d != CH_CR && d != CH_LF) begin
                    clear_decoder();
                    size_line_char(d, cause);
                end
            end
            PH_SIZE: begin
                size_line_char(d, cause);
            end
            PH_SKIP: begin
                if (d == CH_LF) close_size_line(cause);
            end
            PH_DATA: begin
                res.body_byte = d;
                res.byte_valid = 1'b1;
                produced = 1'b1;
                if (dec_remaining != '0) dec_remaining = dec_remaining - 1'b1;
                if (dec_remaining == '0) dec_phase = PH_TRAIL;
            end
            default: begin
            end
        endcase
        if (cause != CAUSE_NONE) begin
            res.body_end = 1'b1;
            res.end_cause = cause;
            produced = 1'b1;
            dec_phase = PH_DONE;
        end
        // The last beat of a buffer ends an active body and re-arms the decoder.
        if (l) begin
            if (!was_done && cause == CAUSE_NONE) begin
                res.body_end = 1'b1;
                res.end_cause = CAUSE_INPUT;
                produced = 1'b1;
            end
            clear_decoder();
        end
    endtask

    // Present one beat, wait for the handshake and record its expected result.
    task automatic send_byte(input logic [7:0] d, input logic l,
                             input logic typed, input t_result typed_res);
        bit      produced;
        t_result res;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= l;
        do @(posedge i_clk); while (!o_ready);
        sent_beats++;
        if (dec_phase != PH_DONE) decoded_beats++;
        decode_byte(d, l, produced, res);
        if (typed) begin
            produced = 1'b1;
            res = typed_res;
        end
        if (produced) pending_results.push_back(res);
        @(negedge i_clk);
    endtask

    // Hold the input until every expected result has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [7:0] hex_char(input int unsigned v);
        if (v < 10) return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 10);
    endfunction

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) body_q.push_back(s[k]);
    endtask

    task automatic push_line_end();
        if ($urandom_range(0, 3) != 0) body_q.push_back(CH_CR);
        body_q.push_back(CH_LF);
    endtask

    task automatic push_payload(input int unsigned n);
        repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Size line in random case, sometimes with a leading zero or an extension.
    task automatic push_size_line(input int unsigned sz);
        logic [7:0]  digits[$];
        int unsigned rest;
        rest = sz;
        do begin
            digits.push_front(hex_char(rest % 16));
            rest = rest / 16;
        end while (rest != 0);
        if ($urandom_range(0, 4) == 0) digits.push_front("0");
        foreach (digits[k]) body_q.push_back(digits[k]);
        case ($urandom_range(0, 5))
            0: push_text(";ext=a1");
            1: push_text(" ");
            2: push_text(";q");
            default: ;
        endcase
        push_line_end();
    endtask

    // Build one input buffer: mostly well-formed bodies, the rest broken or noise.
    task automatic make_buffer();
        int unsigned kind;
        int unsigned sz;
        logic [7:0]  b;
        body_q = {};
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
            repeat ($urandom_range(1, 4)) begin
                sz = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                 : $urandom_range(1, 12);
                push_size_line(sz);
                push_payload(sz);
                case ($urandom_range(0, 3))
                    0: ;
                    1: body_q.push_back(CH_LF);
                    default: push_line_end();
                endcase
            end
            push_size_line(0);
            if ($urandom_range(0, 1) != 0) push_line_end();
            if ($urandom_range(0, 3) == 0) push_text("trailer");
        end else if (kind < 16) begin
            // Oversized chunk: the size saturates and the buffer ends mid-payload.
            body_q.push_back("F");
            repeat ($urandom_range(8, 11)) body_q.push_back(hex_char($urandom_range(0, 15)));
            push_line_end();
            push_payload($urandom_range(1, 6));
        end else if (kind < 18) begin
            // Size line without digits, possibly carrying text and late digits.
            if ($urandom_range(0, 2) != 0) begin
                body_q.push_back(";");
                repeat ($urandom_range(0, 5)) begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
                    body_q.push_back(b);
                end
            end
            body_q.push_back(CH_LF);
            push_payload($urandom_range(0, 4));
        end else begin
            push_payload($urandom_range(1, 24));
        end
        // Some buffers are cut short at a random point.
        if ($urandom_range(0, 4) == 0 && body_q.size() > 1) begin
            body_q = body_q[0:$urandom_range(0, body_q.size() - 2)];
        end
    endtask

    // Output side stalls at random.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    task automatic flag_mismatch(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= MAX_ERR_PRINT) begin
            $display("%0t %s: expected byte %02h valid %0d end %0d cause %0d",
                     $realtime, what, want.body_byte, want.byte_valid, want.body_end,
                     want.end_cause);
            $display("    got byte %02h valid %0d end %0d cause %0d",
                     got.body_byte, got.byte_valid, got.body_end, got.end_cause);
        end
    endtask

    // Compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got.body_byte = o_body_byte;
            got.byte_valid = o_byte_valid;
            got.body_end = o_body_end;
            got.end_cause = t_cause'(o_end_cause);
            if (got.byte_valid === 1'b1) payload_beats++;
            if (got.body_end === 1'b1) ends_by_cause[got.end_cause]++;
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing expected", NO_RES, got);
            end else begin
                want = pending_results.pop_front();
                if (got.body_byte !== want.body_byte || got.byte_valid !== want.byte_valid ||
                    got.body_end !== want.body_end || got.end_cause !== want.end_cause) begin
                    flag_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then three random stages.
    initial begin
        int unsigned stage_goal;
        src_idle_pct = 7;
        sink_idle_pct = 63;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < N_DIR; k++) begin
            send_byte(DIR_ROWS[k].data, DIR_ROWS[k].last, DIR_ROWS[k].typed, DIR_ROWS[k].res);
        end
        wait_drained();

        for (int stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin
                    src_idle_pct = 7;
                    sink_idle_pct = 63;
                end
                1: begin
                    src_idle_pct = 63;
                    sink_idle_pct = 7;
                end
                default: begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            stage_goal = decoded_beats + RANDOM_BEATS / 3;
            while (decoded_beats < stage_goal) begin
                make_buffer();
                foreach (body_q[k]) begin
                    send_byte(body_q[k], k == body_q.size() - 1, 1'b0, NO_RES);
                end
                if ($urandom_range(0, 11) == 0) wait_drained();
            end
            wait_drained();
        end

        // Let any late beat show up before the verdict.
        repeat (16) @(posedge i_clk);
        $display("Sent %0d input beats (%0d decoded), %0d payload beats came out.",
                 sent_beats, decoded_beats, payload_beats);
        $display("Body ends: %0d zero-size, %0d without digits, %0d by end of input.",
                 ends_by_cause[CAUSE_ZERO], ends_by_cause[CAUSE_NODIGIT],
                 ends_by_cause[CAUSE_INPUT]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[http_chunked_body_decoder_core] OK");
        end else begin
            $display("[http_chunked_body_decoder_core] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/hcbd_pkg.sv
hdl/hcbd_step.sv
hdl/hcbd_out_buf.sv
hdl/http_chunked_body_decoder_core.sv
sim/tb_http_chunked_body_decoder_core.sv
